>>> sv/gqss_pkg.sv
// ----------------------------------------------------------------------------
// gqss_pkg
// Types and constants shared by the grid-quantized start/stop clock.
// ----------------------------------------------------------------------------
package gqss_pkg;

  localparam int unsigned DVS_W = 26;   // divisor width (tempo is the widest)
  localparam logic [29:0] SECS_MAX = 30'h3FFF_FFFF;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RUN  = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    DIV_GCUR,
    DIV_GPREV,
    DIV_POS,
    DIV_PHASE,
    DIV_SECS
  } div_op_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_GCUR,
    C_GPREV,
    C_UPDATE,
    C_POS,
    C_PHASE,
    C_SECS,
    C_FINISH
  } ctl_e;

  typedef struct packed {
    logic               link_available;
    logic signed [47:0] current_beat;
    logic [25:0]        tempo;
    logic               enable_level;
    logic [24:0]        grid_size;
    logic [24:0]        beat_interval;
  } in_item_t;

  typedef struct packed {
    logic               grid_trigger;
    logic               beat_trigger;
    logic               enabled_envelope;
    logic               signal_trigger;
    logic [15:0]        phase;
    logic               signal_envelope;
    logic               done_trigger;
    logic [1:0]         mode;
    logic [29:0]        block_seconds;
    logic signed [47:0] beat_echo;
  } out_item_t;

  typedef struct packed {
    logic    load;
    logic    div_start;
    div_op_e div_op;
    logic    update;
    logic    finish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> sv/gqss_stream_if.sv
// ----------------------------------------------------------------------------
// gqss_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface gqss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/gqss_div.sv
// ----------------------------------------------------------------------------
// gqss_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gqss_div import gqss_pkg::*; #(
  parameter int unsigned DIV_W = 49
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [DVS_W-1:0]   divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quot_o,
  output logic [DVS_W-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(DIV_W + 1);

  logic               busy_q;
  logic               done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W-1:0]   quot_q;
  logic [DVS_W-1:0]   rem_q;
  logic [DVS_W-1:0]   dvs_q;
  logic [DVS_W:0]     trial;
  logic               ge;

  assign trial = {rem_q, quot_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DIV_W-2:0], ge};
      rem_q  <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

>>> sv/gqss_ctrl.sv
// ----------------------------------------------------------------------------
// gqss_ctrl
// Sequencer: steps a linked item through divisions, update and result load.
// ----------------------------------------------------------------------------
module gqss_ctrl import gqss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_link_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctl_e state_q, state_d;
  logic started_q;
  logic div_state;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      started_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sts_i.div_done) begin
        started_q <= 1'b0;
      end else if (cmd_o.div_start) begin
        started_q <= 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (in_valid_i) begin
          state_d = in_link_i ? C_GCUR : C_FINISH;
        end
      end
      C_GCUR:   if (sts_i.div_done) state_d = C_GPREV;
      C_GPREV:  if (sts_i.div_done) state_d = C_UPDATE;
      C_UPDATE: state_d = C_POS;
      C_POS:    if (sts_i.div_done) state_d = C_PHASE;
      C_PHASE:  if (sts_i.div_done) state_d = C_SECS;
      C_SECS:   if (sts_i.div_done) state_d = C_FINISH;
      C_FINISH: if (sts_i.out_free) state_d = C_IDLE;
      default:  state_d = C_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    div_state = 1'b0;
    case (state_q)
      C_IDLE:   cmd_o.load = in_valid_i;
      C_GCUR: begin
        div_state    = 1'b1;
        cmd_o.div_op = DIV_GCUR;
      end
      C_GPREV: begin
        div_state    = 1'b1;
        cmd_o.div_op = DIV_GPREV;
      end
      C_UPDATE: cmd_o.update = 1'b1;
      C_POS: begin
        div_state    = 1'b1;
        cmd_o.div_op = DIV_POS;
      end
      C_PHASE: begin
        div_state    = 1'b1;
        cmd_o.div_op = DIV_PHASE;
      end
      C_SECS: begin
        div_state    = 1'b1;
        cmd_o.div_op = DIV_SECS;
      end
      C_FINISH: cmd_o.finish = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
    cmd_o.div_start = div_state && !started_q;
  end

  assign in_ready_o = (state_q == C_IDLE);

endmodule

>>> sv/gqss_dp.sv
// ----------------------------------------------------------------------------
// gqss_dp
// Datapath: tick state, shared divider, trigger logic and result register.
// ----------------------------------------------------------------------------
module gqss_dp import gqss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIV_W     = 49
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  in_item_t    in_data_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o
);

  localparam logic [15:0] TOL_RST =
    16'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  logic [15:0]        tol_q;
  mode_e              mode_q, mode_n;
  logic               last_en_q;
  logic signed [47:0] prev_q;
  logic [24:0]        held_q;
  logic signed [47:0] start_q;
  logic signed [25:0] lip_q, lip_n;
  in_item_t           in_q;
  logic signed [25:0] gp_q, lp_q, pos_q;
  logic [15:0]        phase_q;
  logic [29:0]        secs_q;
  logic               strig_q, dtrig_q, btrig_q, hit_q;
  logic               strig_n, dtrig_n, btrig_n;
  logic               out_valid_q;
  out_item_t          out_q, out_n;

  // divider hookup
  logic [DIV_W-1:0]   dvd;
  logic [DVS_W-1:0]   dvs;
  logic               div_done;
  logic [DIV_W-1:0]   quot;
  logic [DVS_W-1:0]   rem;
  logic               dvd_neg;
  logic signed [25:0] srem;

  logic signed [48:0] diff;
  logic [47:0]        cur_abs, prev_abs;
  logic [48:0]        diff_abs;
  logic [30:0]        held60;

  assign diff     = {in_q.current_beat[47], in_q.current_beat} - {start_q[47], start_q};
  assign cur_abs  = in_q.current_beat[47] ? 48'(-in_q.current_beat) : in_q.current_beat;
  assign prev_abs = prev_q[47] ? 48'(-prev_q) : prev_q;
  assign diff_abs = diff[48] ? 49'(-diff) : diff;
  assign held60   = 31'(held_q) * 31'd60;

  always_comb begin
    dvd     = '0;
    dvs     = '0;
    dvd_neg = 1'b0;
    case (cmd_i.div_op)
      DIV_GCUR: begin
        dvd     = DIV_W'(cur_abs);
        dvs     = DVS_W'(in_q.grid_size);
        dvd_neg = in_q.current_beat[47];
      end
      DIV_GPREV: begin
        dvd     = DIV_W'(prev_abs);
        dvs     = DVS_W'(in_q.grid_size);
        dvd_neg = prev_q[47];
      end
      DIV_POS: begin
        dvd     = DIV_W'(diff_abs);
        dvs     = DVS_W'(held_q);
        dvd_neg = diff[48];
      end
      DIV_PHASE: begin
        dvd = DIV_W'({pos_q[24:0], 16'h0000});
        dvs = DVS_W'(held_q);
      end
      DIV_SECS: begin
        dvd = DIV_W'(held60) << FRAC_BITS;
        dvs = in_q.tempo;
      end
      default: dvd = '0;
    endcase
  end

  gqss_div #(.DIV_W(DIV_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // truncating remainder takes the dividend's sign
  assign srem = dvd_neg ? -$signed({1'b0, rem[24:0]}) : $signed({1'b0, rem[24:0]});

  // grid crossing
  logic signed [26:0] tol27, grid27, gp27, lp27;
  logic               hit;
  assign tol27  = $signed({11'b0, tol_q});
  assign grid27 = $signed({2'b0, in_q.grid_size});
  assign gp27   = 27'(gp_q);
  assign lp27   = 27'(lp_q);
  assign hit    = (in_q.grid_size != '0) &&
                  ((gp27 < lp27) || ((lp27 < tol27) && (gp27 > grid27 - tol27)));

  // mode update
  logic chg;
  assign chg = in_q.beat_interval != held_q;

  always_comb begin
    mode_n  = mode_q;
    lip_n   = (chg && (mode_q == MODE_RUN || mode_q == MODE_STOP)) ? '0 : lip_q;
    strig_n = 1'b0;
    dtrig_n = 1'b0;
    btrig_n = 1'b0;
    case (mode_q)
      MODE_IDLE: if (in_q.enable_level && !last_en_q) mode_n = MODE_WAIT;
      MODE_WAIT: begin
        if (!in_q.enable_level) begin
          mode_n = MODE_IDLE;
        end else if (hit) begin
          mode_n  = MODE_RUN;
          lip_n   = '0;
          strig_n = 1'b1;
          btrig_n = 1'b1;
        end
      end
      MODE_RUN: if (!in_q.enable_level) mode_n = MODE_STOP;
      MODE_STOP: begin
        if (in_q.enable_level) begin
          mode_n = MODE_RUN;
        end else if (hit) begin
          mode_n  = MODE_IDLE;
          dtrig_n = 1'b1;
        end
      end
      default: mode_n = MODE_IDLE;
    endcase
  end

  // result assembly
  logic               run;
  logic signed [26:0] pos27, lip27, iv27;
  logic               bt;
  always_comb begin
    run   = (mode_q == MODE_RUN) || (mode_q == MODE_STOP);
    pos27 = (held_q != '0) ? 27'(pos_q) : '0;
    lip27 = 27'(lip_q);
    iv27  = $signed({2'b0, held_q});
    bt    = btrig_q || (run && ((pos27 < lip27) ||
                               ((lip27 < tol27) && (pos27 > iv27 - tol27))));
    out_n = '0;
    if (in_q.link_available) begin
      out_n.grid_trigger     = run && hit_q;
      out_n.beat_trigger     = bt;
      out_n.enabled_envelope = mode_q != MODE_IDLE;
      out_n.signal_trigger   = strig_q;
      out_n.phase            = (run && held_q != '0 && !diff[48]) ? phase_q : '0;
      out_n.signal_envelope  = run;
      out_n.done_trigger     = dtrig_q;
      out_n.mode             = mode_q;
      out_n.block_seconds    = secs_q;
      out_n.beat_echo        = in_q.current_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q       <= TOL_RST;
      mode_q      <= MODE_IDLE;
      last_en_q   <= 1'b0;
      prev_q      <= '0;
      held_q      <= '0;
      start_q     <= '0;
      lip_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
      if (cmd_i.update) begin
        held_q    <= in_q.beat_interval;
        mode_q    <= mode_n;
        lip_q     <= lip_n;
        prev_q    <= in_q.current_beat;
        last_en_q <= in_q.enable_level;
        if (strig_n) begin
          start_q <= in_q.current_beat;
        end
      end
      if (cmd_i.finish && in_q.link_available && run) begin
        lip_q <= pos27[25:0];
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
    if (cmd_i.update) begin
      hit_q   <= hit;
      strig_q <= strig_n;
      dtrig_q <= dtrig_n;
      btrig_q <= btrig_n;
    end
    if (cmd_i.load) begin
      strig_q <= 1'b0;
      dtrig_q <= 1'b0;
      btrig_q <= 1'b0;
    end
    if (div_done) begin
      case (cmd_i.div_op)
        DIV_GCUR:  gp_q    <= srem;
        DIV_GPREV: lp_q    <= srem;
        DIV_POS:   pos_q   <= srem;
        DIV_PHASE: phase_q <= quot[15:0];
        DIV_SECS: begin
          if (in_q.tempo == '0 || quot[DIV_W-1:30] != '0) begin
            secs_q <= SECS_MAX;
          end else begin
            secs_q <= quot[29:0];
          end
        end
        default: phase_q <= phase_q;
      endcase
    end
    if (cmd_i.finish) begin
      out_q <= out_n;
    end
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

>>> sv/grid_quantized_start_stop.sv
// ----------------------------------------------------------------------------
// grid_quantized_start_stop
// Grid-quantized start/stop sequencer clock, one result beat per tick beat.
// ----------------------------------------------------------------------------
// One input beat is taken at a time. A tick with link_available high runs five
// divisions through one shared restoring divider that yields one quotient bit per
// cycle (grid remainders of the current and previous beat, interval position,
// phase, block length in seconds) on a dividend of DIV_W = max(49, 31 + FRAC_BITS)
// bits. A tick with link_available low skips the divisions and the update. The
// result sits in an output register, so the next beat is taken while it waits.
// The tolerance register may be written at any time the block is idle; it takes
// effect on the next tick.
// ----------------------------------------------------------------------------
module grid_quantized_start_stop import gqss_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gqss_stream_if.sink   in_i,
  gqss_stream_if.source out_o,
  gqss_stream_if.sink   cfg_i
);

  localparam int unsigned DIV_W = (31 + FRAC_BITS > 49) ? 31 + FRAC_BITS : 49;

  cmd_t cmd;
  sts_t sts;

  gqss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_link_i  (in_i.data.link_available),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gqss_dp #(
    .FRAC_BITS (FRAC_BITS),
    .DIV_W     (DIV_W)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign cfg_i.ready = 1'b1;

endmodule

>>> test/grid_quantized_start_stop_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_quantized_start_stop_tb
// Self-checking bench for the grid-quantized start/stop clock: a directed
// table, then random tick sequences under three idle patterns; each result is
// checked field by field against a typed want or a model of the state machine.
// ----------------------------------------------------------------------------
module grid_quantized_start_stop_tb;
  import gqss_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam longint ONE_BEAT = 64'sd1 << FRAC_BITS;
  localparam int unsigned WDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RAND_PER_PHASE = 510;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  gqss_stream_if #(.T(in_item_t))    tick_if ();
  gqss_stream_if #(.T(out_item_t))   res_if ();
  gqss_stream_if #(.T(logic [15:0])) cfg_if ();

  grid_quantized_start_stop #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tick_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // model state
  logic [15:0] tol_q;
  mode_e       mode_q;
  logic        last_en_q;
  longint      prev_beat_q;
  longint      held_iv_q;
  longint      run_start_q;
  longint      last_pos_q;

  out_item_t   expected_q[$];
  int          errors;
  int          sender_idle;
  int          recv_idle;
  int          quiet_cycles;

  task automatic model_tick(input in_item_t it, output out_item_t r);
    longint cur, grid, iv, gp, lp, pos, el, tol, secs;
    logic hit;
    cur  = longint'(it.current_beat);
    grid = longint'({1'b0, it.grid_size});
    tol  = longint'({1'b0, tol_q});
    hit  = 1'b0;
    r    = '0;
    if (!it.link_available) return;
    if (longint'({1'b0, it.beat_interval}) != held_iv_q) begin
      held_iv_q = longint'({1'b0, it.beat_interval});
      if (mode_q == MODE_RUN || mode_q == MODE_STOP) last_pos_q = 0;
    end
    iv = held_iv_q;
    if (grid > 0) begin
      gp = cur % grid;
      lp = prev_beat_q % grid;
      if (gp < lp || (lp < tol && gp > grid - tol)) hit = 1'b1;
    end
    case (mode_q)
      MODE_IDLE: if (it.enable_level && !last_en_q) mode_q = MODE_WAIT;
      MODE_WAIT: begin
        if (!it.enable_level) begin
          mode_q = MODE_IDLE;
        end else if (hit) begin
          mode_q = MODE_RUN;
          run_start_q = cur;
          last_pos_q = 0;
          r.signal_trigger = 1'b1;
          r.beat_trigger = 1'b1;
        end
      end
      MODE_RUN: if (!it.enable_level) mode_q = MODE_STOP;
      default: begin
        if (it.enable_level) begin
          mode_q = MODE_RUN;
        end else if (hit) begin
          mode_q = MODE_IDLE;
          r.done_trigger = 1'b1;
        end
      end
    endcase
    if (mode_q == MODE_RUN || mode_q == MODE_STOP) begin
      pos = 0;
      if (hit) r.grid_trigger = 1'b1;
      if (iv > 0) pos = (cur - run_start_q) % iv;
      if (pos < last_pos_q || (last_pos_q < tol && pos > iv - tol)) r.beat_trigger = 1'b1;
      last_pos_q = pos;
      el = cur - run_start_q;
      if (el < 0) el = 0;
      if (iv > 0) r.phase = 16'(((el % iv) << 16) / iv);
      r.signal_envelope = 1'b1;
    end
    if (it.tempo == '0) begin
      secs = longint'(SECS_MAX);
    end else begin
      secs = ((60 * held_iv_q) << FRAC_BITS) / longint'({1'b0, it.tempo});
      if (secs > longint'(SECS_MAX)) secs = longint'(SECS_MAX);
    end
    r.block_seconds    = 30'(secs);
    r.enabled_envelope = (mode_q != MODE_IDLE);
    r.mode             = mode_q;
    r.beat_echo        = it.current_beat;
    prev_beat_q = cur;
    last_en_q   = it.enable_level;
  endtask

  // valid stays up after the accepting edge until the next beat or an idle cycle
  task automatic send_tick(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t r;
    while ($urandom_range(99) < sender_idle) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= it;
    do @(posedge clk_i); while (!tick_if.ready);
    model_tick(it, r);
    expected_q.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    tick_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_tol(input logic [15:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    tol_q = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // result side: ready at the falling edge, sampled at the rising edge
  always @(negedge clk_i) res_if.ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    out_item_t w, a;
    if (rst_ni) begin
      if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (res_if.valid && res_if.ready) begin
        a = res_if.data;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat %p", $time, a);
        end else begin
          w = expected_q.pop_front();
          check_field("grid_trigger", w.grid_trigger, a.grid_trigger);
          check_field("beat_trigger", w.beat_trigger, a.beat_trigger);
          check_field("enabled_envelope", w.enabled_envelope, a.enabled_envelope);
          check_field("signal_trigger", w.signal_trigger, a.signal_trigger);
          check_field("phase", w.phase, a.phase);
          check_field("signal_envelope", w.signal_envelope, a.signal_envelope);
          check_field("done_trigger", w.done_trigger, a.done_trigger);
          check_field("mode", w.mode, a.mode);
          check_field("block_seconds", w.block_seconds, a.block_seconds);
          check_field("beat_echo", w.beat_echo, a.beat_echo);
        end
      end
    end
  end

  typedef struct {
    in_item_t  tick;
    logic      typed;
    out_item_t want;
  } row_t;

  function automatic in_item_t mk(logic link, longint beat, logic [25:0] tempo, logic en,
                                  logic [24:0] grid, logic [24:0] iv);
    in_item_t t;
    t.link_available = link;
    t.current_beat   = 48'(beat);
    t.tempo          = tempo;
    t.enable_level   = en;
    t.grid_size      = grid;
    t.beat_interval  = iv;
    return t;
  endfunction

  initial begin
    row_t        dir_rows[$];
    row_t        rw;
    in_item_t    t;
    out_item_t   r;
    longint      beat;
    logic [24:0] grid, iv;
    logic        en;
    int          ph;

    tick_if.valid = 1'b0;
    tick_if.data  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    res_if.ready  = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    sender_idle = 0;
    recv_idle = 0;
    tol_q = 16'd655;
    mode_q = MODE_IDLE;
    last_en_q = 1'b0;
    prev_beat_q = 0;
    held_iv_q = 0;
    run_start_q = 0;
    last_pos_q = 0;

    // directed table; link-low rows carry their all-zero result typed in
    rw.typed = 1'b1; rw.want = '0;
    rw.tick = mk(1'b0, -1, '1, 1'b1, '1, '1);                        dir_rows.push_back(rw);
    rw.typed = 1'b0;
    rw.tick = mk(1'b1, 0, 26'd65536, 1'b0, 25'h10000, 25'h10000);      dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 100, 26'd7864320, 1'b1, 25'h10000, 25'h10000);  dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 70000, 26'd7864320, 1'b1, 25'h10000, 25'h8000); dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 100000, 26'd7864320, 1'b1, 25'h10000, 25'h8000);dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 140000, 26'd0, 1'b1, 25'h10000, 25'h0);          dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 140000, 26'd1, 1'b1, 25'h0, 25'h1000000);        dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 10, 26'd65470464, 1'b1, 25'h10000, 25'h10000);  dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 200000, '1, 1'b0, 25'h10000, 25'h10000);        dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 200001, '1, 1'b1, 25'h10000, 25'h10000);        dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 200002, 26'd65536, 1'b0, 25'h10000, 25'h10000); dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 262150, 26'd65536, 1'b0, 25'h10000, 25'h10000); dir_rows.push_back(rw);
    rw.typed = 1'b1;
    rw.tick = mk(1'b0, 5, 26'd65536, 1'b1, 25'h1, 25'h1);              dir_rows.push_back(rw);
    rw.typed = 1'b0;
    rw.tick = mk(1'b1, 0, 26'd65536, 1'b1, 25'h1000000, 25'h1);         dir_rows.push_back(rw);
    rw.tick = mk(1'b1, -140737488355328, '1, 1'b1, 25'h1, 25'h1000000); dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 140737488355327, '1, 1'b1, 25'h1, 25'h1);        dir_rows.push_back(rw);
    rw.tick = mk(1'b1, -70000, 26'd65536, 1'b1, 25'h10000, 25'h10000); dir_rows.push_back(rw);
    rw.tick = mk(1'b1, -1000, 26'd65536, 1'b1, 25'h10000, 25'h1ffffff);dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 65500, 26'd65536, 1'b0, 25'h10000, 25'h1ffffff);dir_rows.push_back(rw);
    rw.tick = mk(1'b1, 65600, 26'd65536, 1'b0, 25'h10000, 25'h1ffffff);dir_rows.push_back(rw);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    write_tol(16'd0);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
    drain();
    write_tol(16'hFFFF);
    foreach (dir_rows[i]) send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);

    beat = 0;
    grid = 25'h10000;
    iv   = 25'h10000;
    en   = 1'b0;
    for (ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin sender_idle = 17; recv_idle = 80; write_tol(16'd655); end
        1: begin sender_idle = 80; recv_idle = 17; write_tol(16'hFFFF); end
        default: begin sender_idle = 0; recv_idle = 0; write_tol(16'($urandom_range(0, 4000))); end
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (ph == 0 && k == RAND_PER_PHASE / 2) drain();
        if ($urandom_range(99) < 90) begin
          // well-formed run of ticks with advancing beat
          beat = beat + longint'($urandom_range(0, 32768));
          if ($urandom_range(99) < 8) en = ~en;
          if ($urandom_range(99) < 3) grid = 25'(ONE_BEAT << $urandom_range(0, 2));
          if ($urandom_range(99) < 3) begin
            case ($urandom_range(3))
              0: iv = 25'h4000;
              1: iv = 25'h8000;
              2: iv = 25'h30000;
              default: iv = 25'(ONE_BEAT);
            endcase
          end
          t = mk($urandom_range(99) >= 3, beat,
                 26'($urandom_range(65536, 65470464)), en, grid, iv);
        end else begin
          t = in_item_t'(126'({$urandom(), $urandom(), $urandom(), $urandom()}));
          if ($urandom_range(1)) beat = longint'(t.current_beat);
        end
        send_tick(t, 1'b0, r);
      end
    end
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
sv/gqss_pkg.sv
sv/gqss_stream_if.sv
sv/gqss_div.sv
sv/gqss_ctrl.sv
sv/gqss_dp.sv
sv/grid_quantized_start_stop.sv
test/grid_quantized_start_stop_tb.sv
